// ===== design/name_hash_chain_lookup_core_macros.svh =====
// Assertion macros used by the name directory checker.
`ifndef NAME_HASH_CHAIN_LOOKUP_CORE_MACROS_SVH
`define NAME_HASH_CHAIN_LOOKUP_CORE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define NHC_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define NHC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/nhc_pkg.sv =====
// Shared types, constants and functions of the name directory.
package nhc_pkg;

   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int NAME_W          = 64;
   localparam int ACTION_W        = 2;
   localparam int STATUS_W        = 3;
   localparam int INDEX_W         = 12;
   localparam int COUNT_W         = 13;
   localparam int HASH_W          = 32;
   localparam int NAME_BYTES      = 8;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [HASH_W-1:0]  HASH_SEED         = 32'd1315423911;
   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 13'd1;

   // Register index taken from the word address
   localparam logic [CSR_ADDR_W-3:0] REG_ENTRY_COUNT = 1'b0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   // Request to the bucket unit
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] modulus;
      logic [NAME_W-1:0]  name;
   } bucket_req_type;

   // Answer of the bucket unit
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] bucket;
   } bucket_rsp_type;

   // One character step of the hash, with the character folded to upper case
   function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] c);
      logic [7:0] u;
      u = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
      return h ^ ((h << 5) + {24'b0, u} + (h >> 2));
   endfunction

   // Byte compare that stops at a NUL both names hold
   function automatic logic names_equal(input logic [NAME_W-1:0] a,
                                        input logic [NAME_W-1:0] b);
      logic       eq;
      logic       stop;
      logic [7:0] x;
      logic [7:0] y;
      eq   = 1'b1;
      stop = 1'b0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         x = a[8*k +: 8];
         y = b[8*k +: 8];
         if (!stop) begin
            if (x != y) begin
               eq   = 1'b0;
               stop = 1'b1;
            end else if (x == 8'h00) begin
               stop = 1'b1;
            end
         end
      end
      return eq;
   endfunction

endpackage

// ===== design/nhc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/nhc_bucket.sv =====
// Bucket unit: byte-serial name hash followed by a bit-serial remainder.
module nhc_bucket import nhc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  bucket_req_type req,
   output bucket_rsp_type rsp
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_HASH,
      B_MOD
   } bstate_type;

   bstate_type         state_ff;
   logic [HASH_W-1:0]  hash_ff;
   logic [NAME_W-1:0]  name_ff;
   logic [COUNT_W-1:0] mod_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [2:0]         byte_cnt_ff;
   logic [4:0]         bit_cnt_ff;
   logic               done_ff;

   logic [7:0]         cur_char;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   rem_in;

   assign cur_char = name_ff[7:0];

   // One restoring divide step on the next hash bit
   always_comb begin
      trial = {rem_ff, hash_ff[HASH_W-1]};
      if (trial >= {1'b0, mod_ff}) begin
         rem_in = trial - {1'b0, mod_ff};
      end else begin
         rem_in = trial;
      end
   end

   // Hash one byte a cycle, then reduce one bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (req.start) begin
                  hash_ff     <= HASH_SEED;
                  name_ff     <= req.name;
                  mod_ff      <= req.modulus;
                  byte_cnt_ff <= '0;
                  state_ff    <= B_HASH;
               end
            end
            B_HASH: begin
               bit_cnt_ff <= '0;
               rem_ff     <= '0;
               if (cur_char == 8'h00) begin
                  state_ff <= B_MOD;
               end else begin
                  hash_ff     <= hash_step(hash_ff, cur_char);
                  name_ff     <= name_ff >> 8;
                  byte_cnt_ff <= byte_cnt_ff + 3'd1;
                  if (byte_cnt_ff == 3'(NAME_BYTES - 1)) begin
                     state_ff <= B_MOD;
                  end
               end
            end
            B_MOD: begin
               rem_ff     <= rem_in[COUNT_W-1:0];
               hash_ff    <= hash_ff << 1;
               bit_cnt_ff <= bit_cnt_ff + 5'd1;
               if (bit_cnt_ff == 5'(HASH_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.bucket = rem_ff;

endmodule

// ===== design/name_hash_chain_lookup_core.sv =====
// Sequence: the hash walks the name bytes through the first NUL, the bucket
// remainder is reduced bit-serially, then the head is read and a lookup visits
// the chain entry by entry; a clear sweeps all bucket heads to zero.
// Throughput: one item at a time, paced by the bucket unit and the entry memory port.
// Reset: synchronous; afterwards a sweep zeroes the bucket heads with req_stall
// high; register writes are taken throughout.
module name_hash_chain_lookup_core import nhc_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [NAME_W-1:0]     req_entry_name,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_entry_index,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int PTR_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ENT_W  = NAME_W + PTR_W;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_HASH,
      S_HEAD_RD,
      S_HEAD,
      S_ENT,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [PTR_W-1:0]   filled_ff;
   logic [IDX_W-1:0]   sweep_ff;
   logic [IDX_W-1:0]   bucket_ff;
   logic [IDX_W-1:0]   cur_ff;
   action_type         action_ff;
   logic [NAME_W-1:0]  name_ff;
   status_type         res_status_ff;
   logic [IDX_W-1:0]   res_index_ff;
   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0] rsp_index_ff;

   logic [COUNT_W-1:0] n_eff;
   logic               insert_full;
   logic               req_accept;
   logic               sweep_last;
   logic               rsp_free;
   action_type         req_act;

   logic               head_wr_en;
   logic [IDX_W-1:0]   head_wr_addr;
   logic [PTR_W-1:0]   head_wr_data;
   logic [PTR_W-1:0]   head_q;
   logic               ent_wr_en;
   logic [ENT_W-1:0]   ent_wr_data;
   logic [IDX_W-1:0]   ent_rd_addr;
   logic [ENT_W-1:0]   ent_q;
   logic [NAME_W-1:0]  ent_name;
   logic [PTR_W-1:0]   ent_next;

   bucket_req_type     bkt_req;
   bucket_rsp_type     bkt_rsp;

   // Clamp the modulus to the table size
   always_comb begin
      if (32'(entry_count_ff) > 32'(MAX_ENTRIES)) begin
         n_eff = COUNT_W'(MAX_ENTRIES);
      end else begin
         n_eff = entry_count_ff;
      end
   end

   assign insert_full = (n_eff == '0) || (32'(filled_ff) >= 32'(n_eff));
   assign req_act     = action_type'(req_action);
   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign sweep_last  = (sweep_ff == IDX_W'(MAX_ENTRIES - 1));
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // Start the bucket unit for inserts with room and for lookups with a nonzero modulus
   always_comb begin
      bkt_req.modulus = n_eff;
      bkt_req.name    = req_entry_name;
      bkt_req.start   = 1'b0;
      if (req_accept) begin
         if (req_act == ACT_INSERT) begin
            bkt_req.start = !insert_full;
         end else if (req_act == ACT_LOOKUP) begin
            bkt_req.start = (n_eff != '0);
         end
      end
   end

   nhc_bucket u_bucket (
      .clock (clock),
      .reset (reset),
      .req   (bkt_req),
      .rsp   (bkt_rsp)
   );

   // Head memory writes: zero sweep or new chain head on insert
   always_comb begin
      head_wr_en   = 1'b0;
      head_wr_addr = sweep_ff;
      head_wr_data = '0;
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         head_wr_en = 1'b1;
      end else if (state_ff == S_HEAD && action_ff == ACT_INSERT) begin
         head_wr_en   = 1'b1;
         head_wr_addr = bucket_ff;
         head_wr_data = filled_ff + PTR_W'(1);
      end
   end

   nhc_ram #(
      .WIDTH (PTR_W),
      .DEPTH (MAX_ENTRIES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_addr (bucket_ff),
      .rd_data (head_q)
   );

   // Entry memory: name and chain link side by side
   assign ent_wr_en   = (state_ff == S_HEAD) && (action_ff == ACT_INSERT);
   assign ent_wr_data = {name_ff, head_q};
   assign ent_name    = ent_q[ENT_W-1:PTR_W];
   assign ent_next    = ent_q[PTR_W-1:0];

   always_comb begin
      if (state_ff == S_HEAD) begin
         ent_rd_addr = IDX_W'(head_q - PTR_W'(1));
      end else begin
         ent_rd_addr = IDX_W'(ent_next - PTR_W'(1));
      end
   end

   nhc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (IDX_W'(filled_ff)),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_q)
   );

   // Sequencer: one item at a time, so a head written on insert is never
   // read back before the write has landed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               sweep_ff <= sweep_ff + IDX_W'(1);
               if (sweep_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  action_ff    <= req_act;
                  name_ff      <= req_entry_name;
                  res_index_ff <= '0;
                  sweep_ff     <= '0;
                  unique case (req_act)
                     ACT_INSERT: begin
                        if (insert_full) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_HASH;
                        end
                     end
                     ACT_LOOKUP: begin
                        if (n_eff == '0) begin
                           res_status_ff <= ST_NOT_FOUND;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_HASH;
                        end
                     end
                     ACT_CLEAR: begin
                        filled_ff <= '0;
                        state_ff  <= S_CLEAR;
                     end
                     ACT_NONE: begin
                        res_status_ff <= ST_NOT_FOUND;
                        state_ff      <= S_DONE;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_HASH: begin
               if (bkt_rsp.done) begin
                  bucket_ff <= IDX_W'(bkt_rsp.bucket);
                  state_ff  <= S_HEAD_RD;
               end
            end
            S_HEAD_RD: begin
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               if (action_ff == ACT_INSERT) begin
                  res_status_ff <= ST_INSERTED;
                  res_index_ff  <= IDX_W'(filled_ff);
                  filled_ff     <= filled_ff + PTR_W'(1);
                  state_ff      <= S_DONE;
               end else if (head_q == '0) begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_DONE;
               end else begin
                  cur_ff   <= IDX_W'(head_q - PTR_W'(1));
                  state_ff <= S_ENT;
               end
            end
            S_ENT: begin
               if (names_equal(ent_name, name_ff)) begin
                  res_status_ff <= ST_FOUND;
                  res_index_ff  <= cur_ff;
                  state_ff      <= S_DONE;
               end else if (ent_next == '0) begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_DONE;
               end else begin
                  cur_ff <= ent_rd_addr;
               end
            end
            S_CLEAR: begin
               sweep_ff <= sweep_ff + IDX_W'(1);
               if (sweep_last) begin
                  res_status_ff <= ST_CLEARED;
                  state_ff      <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_index_ff  <= INDEX_W'(res_index_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

   // Register port
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CSR_ADDR_W-1:2] == REG_ENTRY_COUNT) begin
         entry_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_ENTRY_COUNT) begin
         csr_prdata = CSR_DATA_W'(entry_count_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign csr_pready = 1'b1;

endmodule

// ===== design/nhc_checker.sv =====
// Port-level checks of the name directory, bound to the top level.
`include "name_hash_chain_lookup_core_macros.svh"

module nhc_checker import nhc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [INDEX_W-1:0]  rsp_entry_index
);

   // Hold a stalled result word
   `NHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_index), "stalled result changed")

   // Only defined status codes leave the block
   `NHC_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_status == ST_INSERTED || rsp_status == ST_FOUND || rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL || rsp_status == ST_CLEARED, "undefined status")

   // Drop the index on answers that carry none
   `NHC_ASSERT_SAME(a_index_zero, clock, reset, rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL || rsp_status == ST_CLEARED), rsp_entry_index == '0, "index set on empty answer")

   // Go busy right after taking a word
   `NHC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "second word taken while busy")

endmodule

bind name_hash_chain_lookup_core nhc_checker u_nhc_checker (.*);
